>>> src/itrt_pkg.sv
// ----------------------------------------------------------------------------
// Integer to radix text: shared package
// Types, constants and the digit-to-ASCII map for the radix text converter.
// ----------------------------------------------------------------------------
package itrt_pkg;

   localparam int VALUE_WIDTH = 32;
   localparam int RADIX_WIDTH = 6;
   localparam int CHAR_WIDTH  = 8;
   localparam int REM_WIDTH   = RADIX_WIDTH + 1;
   localparam int PROD_WIDTH  = 2 * VALUE_WIDTH;
   localparam int DIGIT_DEPTH = VALUE_WIDTH;
   localparam int DIGIT_IDX_W = $clog2(DIGIT_DEPTH);
   localparam int DIGIT_CNT_W = DIGIT_IDX_W + 1;

   localparam logic [RADIX_WIDTH-1:0] RADIX_MIN     = RADIX_WIDTH'(2);
   localparam logic [RADIX_WIDTH-1:0] RADIX_MAX     = RADIX_WIDTH'(36);
   localparam logic [RADIX_WIDTH-1:0] RADIX_DECIMAL = RADIX_WIDTH'(10);
   localparam logic [CHAR_WIDTH-1:0]  CHAR_MINUS    = 8'h2d;
   localparam logic [CHAR_WIDTH-1:0]  CHAR_NONE     = 8'h00;
   localparam logic [CHAR_WIDTH-1:0]  CHAR_ZERO     = 8'h30;
   localparam logic [CHAR_WIDTH-1:0]  CHAR_LETTER   = 8'h57;  // 'a' - 10

   // floor(2^VALUE_WIDTH / r): quotient estimate is low by at most one
   localparam logic [PROD_WIDTH-1:0] RECIP_NUM = PROD_WIDTH'(1) << VALUE_WIDTH;
   localparam logic [VALUE_WIDTH-1:0] RECIP_TABLE [64] = '{
       2: VALUE_WIDTH'(RECIP_NUM / 2),   3: VALUE_WIDTH'(RECIP_NUM / 3),
       4: VALUE_WIDTH'(RECIP_NUM / 4),   5: VALUE_WIDTH'(RECIP_NUM / 5),
       6: VALUE_WIDTH'(RECIP_NUM / 6),   7: VALUE_WIDTH'(RECIP_NUM / 7),
       8: VALUE_WIDTH'(RECIP_NUM / 8),   9: VALUE_WIDTH'(RECIP_NUM / 9),
      10: VALUE_WIDTH'(RECIP_NUM / 10), 11: VALUE_WIDTH'(RECIP_NUM / 11),
      12: VALUE_WIDTH'(RECIP_NUM / 12), 13: VALUE_WIDTH'(RECIP_NUM / 13),
      14: VALUE_WIDTH'(RECIP_NUM / 14), 15: VALUE_WIDTH'(RECIP_NUM / 15),
      16: VALUE_WIDTH'(RECIP_NUM / 16), 17: VALUE_WIDTH'(RECIP_NUM / 17),
      18: VALUE_WIDTH'(RECIP_NUM / 18), 19: VALUE_WIDTH'(RECIP_NUM / 19),
      20: VALUE_WIDTH'(RECIP_NUM / 20), 21: VALUE_WIDTH'(RECIP_NUM / 21),
      22: VALUE_WIDTH'(RECIP_NUM / 22), 23: VALUE_WIDTH'(RECIP_NUM / 23),
      24: VALUE_WIDTH'(RECIP_NUM / 24), 25: VALUE_WIDTH'(RECIP_NUM / 25),
      26: VALUE_WIDTH'(RECIP_NUM / 26), 27: VALUE_WIDTH'(RECIP_NUM / 27),
      28: VALUE_WIDTH'(RECIP_NUM / 28), 29: VALUE_WIDTH'(RECIP_NUM / 29),
      30: VALUE_WIDTH'(RECIP_NUM / 30), 31: VALUE_WIDTH'(RECIP_NUM / 31),
      32: VALUE_WIDTH'(RECIP_NUM / 32), 33: VALUE_WIDTH'(RECIP_NUM / 33),
      34: VALUE_WIDTH'(RECIP_NUM / 34), 35: VALUE_WIDTH'(RECIP_NUM / 35),
      36: VALUE_WIDTH'(RECIP_NUM / 36),
      default: '0
   };

   typedef struct packed {
      logic signed [VALUE_WIDTH-1:0] value;
      logic [RADIX_WIDTH-1:0]        radix;
   } req_type;

   typedef struct packed {
      logic [CHAR_WIDTH-1:0] text_char;
      logic                  last_char;
      logic                  bad_radix;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_BACK,
      ST_FIX,
      ST_DRAIN
   } state_type;

   function automatic logic radix_bad(input logic [RADIX_WIDTH-1:0] r);
      return (r < RADIX_MIN) || (r > RADIX_MAX);
   endfunction

   function automatic logic [CHAR_WIDTH-1:0] digit_char(input logic [RADIX_WIDTH-1:0] d);
      logic [CHAR_WIDTH-1:0] d_ext;
      d_ext = CHAR_WIDTH'(d);
      if (d < RADIX_WIDTH'(10)) begin
         return CHAR_ZERO + d_ext;
      end
      return CHAR_LETTER + d_ext;
   endfunction

endpackage

>>> src/integer_to_radix_text.sv
// ----------------------------------------------------------------------------
// Integer to radix text
// Converts an integer (signed in radix 10 only) to ASCII text in radix 2..36, most
// significant digit first, over one shared multiplier under a small sequencer.
// ----------------------------------------------------------------------------
// A bad radix or a radix-10 '-' shows its result in the cycle after the request.
// Each digit passes the shared multiplier as reciprocal multiply, back-multiply
//   and correct; the digit store is then read back in reverse. A value gives
//   1..32 digits; the last character shows as busy falls.
// A new request is taken only while idle, and a bad radix leaves it idle; no stalls.
// Reset: sequencer to idle, no result pending; digit store is not cleared.
module integer_to_radix_text (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  itrt_pkg::req_type req_data,
   output logic             rsp_valid,
   output itrt_pkg::rsp_type rsp_data
);

   itrt_pkg::state_type state_ff, state_in;

   logic [itrt_pkg::VALUE_WIDTH-1:0] mag_ff;
   logic [itrt_pkg::RADIX_WIDTH-1:0] radix_ff;
   logic [itrt_pkg::VALUE_WIDTH-1:0] q_ff;
   logic [itrt_pkg::REM_WIDTH-1:0]   qr_ff;
   logic [itrt_pkg::DIGIT_CNT_W-1:0] len_ff;
   logic [itrt_pkg::DIGIT_IDX_W-1:0] rd_idx_ff;
   logic [itrt_pkg::RADIX_WIDTH-1:0] digit_rd_ff;
   logic [itrt_pkg::RADIX_WIDTH-1:0] digit_mem [itrt_pkg::DIGIT_DEPTH];

   logic out_valid_ff, out_last_ff, out_bad_ff, out_sign_ff;

   // sequencer controls
   logic take_req, load_err, load_run, load_neg;
   logic cap_q, cap_qr, fix_en, drain_en, mul_sel_recip;

   // shared multiplier
   logic [itrt_pkg::VALUE_WIDTH-1:0] mul_a, mul_b;
   logic [itrt_pkg::PROD_WIDTH-1:0]  prod;

   // correction
   logic [itrt_pkg::REM_WIDTH-1:0]   rem_raw, rem_fix;
   logic                             rem_over;
   logic [itrt_pkg::VALUE_WIDTH-1:0] quot;
   logic                             quot_zero;
   logic [itrt_pkg::VALUE_WIDTH-1:0] neg_value;

   assign busy     = (state_ff != itrt_pkg::ST_IDLE);
   assign take_req = start && !busy;

   assign mul_a = mul_sel_recip ? mag_ff : q_ff;
   assign mul_b = mul_sel_recip ? itrt_pkg::RECIP_TABLE[radix_ff]
                                : itrt_pkg::VALUE_WIDTH'(radix_ff);
   assign prod  = itrt_pkg::PROD_WIDTH'(mul_a) * itrt_pkg::PROD_WIDTH'(mul_b);

   // true remainder is below twice the radix, so the low bits suffice
   assign rem_raw   = mag_ff[itrt_pkg::REM_WIDTH-1:0] - qr_ff;
   assign rem_over  = rem_raw >= itrt_pkg::REM_WIDTH'(radix_ff);
   assign rem_fix   = rem_over ? rem_raw - itrt_pkg::REM_WIDTH'(radix_ff) : rem_raw;
   assign quot      = q_ff + itrt_pkg::VALUE_WIDTH'(rem_over);
   assign quot_zero = (quot == '0);
   assign neg_value = itrt_pkg::VALUE_WIDTH'(0) - req_data.value;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         itrt_pkg::ST_IDLE: begin
            if (take_req && !itrt_pkg::radix_bad(req_data.radix)) begin
               state_in = itrt_pkg::ST_MUL;
            end
         end
         itrt_pkg::ST_MUL:  state_in = itrt_pkg::ST_BACK;
         itrt_pkg::ST_BACK: state_in = itrt_pkg::ST_FIX;
         itrt_pkg::ST_FIX: begin
            state_in = quot_zero ? itrt_pkg::ST_DRAIN : itrt_pkg::ST_MUL;
         end
         itrt_pkg::ST_DRAIN: begin
            if (rd_idx_ff == '0) begin
               state_in = itrt_pkg::ST_IDLE;
            end
         end
         default: state_in = itrt_pkg::ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      load_err      = 1'b0;
      load_run      = 1'b0;
      load_neg      = 1'b0;
      cap_q         = 1'b0;
      cap_qr        = 1'b0;
      fix_en        = 1'b0;
      drain_en      = 1'b0;
      mul_sel_recip = 1'b0;
      unique case (state_ff)
         itrt_pkg::ST_IDLE: begin
            if (take_req) begin
               load_err = itrt_pkg::radix_bad(req_data.radix);
               load_run = !itrt_pkg::radix_bad(req_data.radix);
               load_neg = (req_data.radix == itrt_pkg::RADIX_DECIMAL)
                          && req_data.value[itrt_pkg::VALUE_WIDTH-1];
            end
         end
         itrt_pkg::ST_MUL: begin
            mul_sel_recip = 1'b1;
            cap_q         = 1'b1;
         end
         itrt_pkg::ST_BACK:  cap_qr   = 1'b1;
         itrt_pkg::ST_FIX:   fix_en   = 1'b1;
         itrt_pkg::ST_DRAIN: drain_en = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= itrt_pkg::ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= load_err || (load_run && load_neg) || drain_en;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (load_run) begin
         mag_ff   <= load_neg ? neg_value : req_data.value;
         radix_ff <= req_data.radix;
         len_ff   <= '0;
      end
      if (cap_q) begin
         q_ff <= prod[itrt_pkg::PROD_WIDTH-1:itrt_pkg::VALUE_WIDTH];
      end
      if (cap_qr) begin
         qr_ff <= prod[itrt_pkg::REM_WIDTH-1:0];
      end
      if (fix_en) begin
         mag_ff    <= quot;
         len_ff    <= len_ff + itrt_pkg::DIGIT_CNT_W'(1);
         rd_idx_ff <= len_ff[itrt_pkg::DIGIT_IDX_W-1:0];
      end
      if (drain_en) begin
         rd_idx_ff <= rd_idx_ff - itrt_pkg::DIGIT_IDX_W'(1);
      end
   end

   // digit store: written while dividing, read back in reverse
   always_ff @(posedge clock) begin
      if (fix_en) begin
         digit_mem[len_ff[itrt_pkg::DIGIT_IDX_W-1:0]] <= rem_fix[itrt_pkg::RADIX_WIDTH-1:0];
      end
      if (drain_en) begin
         digit_rd_ff <= digit_mem[rd_idx_ff];
      end
   end

   // result marks
   always_ff @(posedge clock) begin
      if (load_err || load_run || drain_en) begin
         out_bad_ff  <= load_err;
         out_sign_ff <= load_run;
         out_last_ff <= load_err || (drain_en && (rd_idx_ff == '0));
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_data.last_char = out_last_ff;
   assign rsp_data.bad_radix = out_bad_ff;

   always_comb begin
      priority if (out_bad_ff) begin
         rsp_data.text_char = itrt_pkg::CHAR_NONE;
      end else if (out_sign_ff) begin
         rsp_data.text_char = itrt_pkg::CHAR_MINUS;
      end else begin
         rsp_data.text_char = itrt_pkg::digit_char(digit_rd_ff);
      end
   end

endmodule

>>> src/itrt_checker.sv
// ----------------------------------------------------------------------------
// Integer to radix text: port checker
// Watches the converter's ports and checks reset, start and result marks.
// ----------------------------------------------------------------------------
module itrt_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input itrt_pkg::req_type req_data,
   input logic              rsp_valid,
   input itrt_pkg::rsp_type rsp_data
);

   // reset leaves the block idle with nothing shown
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !busy && !rsp_valid)
      else $error("block not idle after reset");

   // a bad radix gives one final error result next cycle
   a_bad_radix: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_data.radix < 6'd2 || req_data.radix > 6'd36)
      |=> rsp_valid && rsp_data.bad_radix && rsp_data.last_char && !busy)
      else $error("bad radix request not answered by one error result");

   // a valid radix starts a conversion
   a_run: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_data.radix >= 6'd2 && req_data.radix <= 6'd36 |=> busy)
      else $error("conversion did not start");

   // more text is owed while the last character has not been shown
   a_more_text: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.last_char |-> busy && !rsp_data.bad_radix)
      else $error("request finished before its last character");

   a_error_char: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.bad_radix |-> rsp_data.text_char == 8'h00)
      else $error("error result carries text");

endmodule

bind integer_to_radix_text itrt_checker u_itrt_checker (.*);

>>> bench/tb_integer_to_radix_text.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Integer to radix text: testbench
// Drives signed values and radices into the converter, predicts the text of
// each request and checks every character, its last mark and the radix
// error flag in order, with random sender gaps and a no-progress watchdog.
// ----------------------------------------------------------------------------
module tb_integer_to_radix_text;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int SETTLE_CYCLES  = 4 * itrt_pkg::DIGIT_DEPTH + 16;
   localparam logic [itrt_pkg::CHAR_WIDTH-1:0] CHAR_LOWER_A = 8'h61;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   itrt_pkg::req_type req_data = '0;
   logic              rsp_valid;
   itrt_pkg::rsp_type rsp_data;

   itrt_pkg::rsp_type expected_text[$];
   int                error_count = 0;
   int                stall_cycles = 0;
   int                idle_pct = 16;

   integer_to_radix_text dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Work out the characters one request produces and queue them up.
   function automatic void predict_text(input itrt_pkg::req_type item);
      logic [itrt_pkg::VALUE_WIDTH-1:0] magnitude;
      logic [itrt_pkg::VALUE_WIDTH-1:0] base;
      logic [itrt_pkg::VALUE_WIDTH-1:0] rem;
      logic [itrt_pkg::CHAR_WIDTH-1:0]  digits [0:itrt_pkg::DIGIT_DEPTH-1];
      logic                             negative;
      itrt_pkg::rsp_type                entry;
      int                               count;
      count = 0;
      if (item.radix < itrt_pkg::RADIX_MIN || item.radix > itrt_pkg::RADIX_MAX) begin
         entry.text_char = itrt_pkg::CHAR_NONE;
         entry.last_char = 1'b1;
         entry.bad_radix = 1'b1;
         expected_text.push_back(entry);
         return;
      end
      base      = itrt_pkg::VALUE_WIDTH'(item.radix);
      negative  = (item.radix == itrt_pkg::RADIX_DECIMAL)
                  && item.value[itrt_pkg::VALUE_WIDTH-1];
      magnitude = negative ? (~item.value + 1'b1) : item.value;
      do begin
         rem = magnitude % base;
         if (rem < 10) begin
            digits[count] = itrt_pkg::CHAR_ZERO + rem[itrt_pkg::CHAR_WIDTH-1:0];
         end else begin
            digits[count] = CHAR_LOWER_A + rem[itrt_pkg::CHAR_WIDTH-1:0] - 8'd10;
         end
         count++;
         magnitude = magnitude / base;
      end while (magnitude != 0);
      entry.bad_radix = 1'b0;
      if (negative) begin
         entry.text_char = itrt_pkg::CHAR_MINUS;
         entry.last_char = 1'b0;
         expected_text.push_back(entry);
      end
      for (int i = count - 1; i >= 0; i--) begin
         entry.text_char = digits[i];
         entry.last_char = (i == 0);
         expected_text.push_back(entry);
      end
   endfunction

   // Hold start high across back-to-back requests; lower it only in a gap.
   task automatic send_request(input logic [itrt_pkg::VALUE_WIDTH-1:0] value,
                               input logic [itrt_pkg::RADIX_WIDTH-1:0] radix);
      itrt_pkg::req_type item;
      item.value = value;
      item.radix = radix;
      while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= item;
      do begin
         @(posedge clock);
      end while (busy);
      predict_text(item);
   endtask

   function automatic logic [itrt_pkg::VALUE_WIDTH-1:0] pick_value();
      case ($urandom_range(5))
         0: return itrt_pkg::VALUE_WIDTH'($urandom_range(99));
         1: return -itrt_pkg::VALUE_WIDTH'($urandom_range(99));
         2: return 32'h7fffffff - $urandom_range(3);
         3: return 32'h80000000 + $urandom_range(3);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [itrt_pkg::RADIX_WIDTH-1:0] pick_radix();
      int sel;
      sel = $urandom_range(99);
      if (sel < 10) return itrt_pkg::RADIX_WIDTH'($urandom_range(63));
      if (sel < 25) return itrt_pkg::RADIX_DECIMAL;
      if (sel < 35) begin
         case ($urandom_range(2))
            0: return itrt_pkg::RADIX_MIN;
            1: return itrt_pkg::RADIX_WIDTH'(16);
            default: return itrt_pkg::RADIX_MAX;
         endcase
      end
      return itrt_pkg::RADIX_WIDTH'($urandom_range(2, 36));
   endfunction

   task automatic test_directed();
      send_request(32'd0, itrt_pkg::RADIX_DECIMAL);
      send_request(32'd0, itrt_pkg::RADIX_MIN);
      send_request(32'd0, itrt_pkg::RADIX_MAX);
      send_request(32'h7fffffff, itrt_pkg::RADIX_DECIMAL);
      send_request(32'h80000000, itrt_pkg::RADIX_DECIMAL);
      send_request(32'hffffffff, itrt_pkg::RADIX_DECIMAL);
      send_request(32'hffffffff, 6'd16);
      send_request(32'hffffffff, itrt_pkg::RADIX_MIN);
      send_request(32'h80000000, itrt_pkg::RADIX_MIN);
      send_request(32'h7fffffff, itrt_pkg::RADIX_MAX);
      send_request(32'hffffffff, itrt_pkg::RADIX_MAX);
      send_request(32'd35, itrt_pkg::RADIX_MAX);
      send_request(32'd10, 6'd16);
      send_request(32'd9, itrt_pkg::RADIX_DECIMAL);
      send_request(-32'd5, 6'd8);
      send_request(-32'd7, 6'd3);
      send_request(32'd123, itrt_pkg::RADIX_DECIMAL);
      send_request(32'd1234, 6'd35);
      send_request(32'd42, 6'd0);
      send_request(-32'd42, 6'd1);
      send_request(32'h12345678, 6'd37);
      send_request(32'h80000000, 6'd63);
   endtask

   // Let the block run dry, then resume.
   task automatic test_drain_pause();
      for (int i = 0; i < 6; i++) send_request(pick_value(), pick_radix());
      start <= 1'b0;
      while (expected_text.size() != 0) @(posedge clock);
      for (int i = 0; i < 6; i++) send_request(pick_value(), pick_radix());
   endtask

   task automatic test_back_to_back();
      idle_pct = 0;
      for (int i = 0; i < 100; i++) send_request(pick_value(), pick_radix());
      idle_pct = 16;
   endtask

   task automatic test_random();
      for (int i = 0; i < 250; i++) send_request(pick_value(), pick_radix());
   endtask

   // Check each character against the oldest expectation; watch for a hang.
   always @(posedge clock) begin
      itrt_pkg::rsp_type want;
      if (!reset) begin
         if ((start && !busy) || rsp_valid) begin
            stall_cycles <= 0;
         end else begin
            stall_cycles <= stall_cycles + 1;
         end
         if (rsp_valid) begin
            if (expected_text.size() == 0) begin
               $error("unexpected result: text_char %h", rsp_data.text_char);
               error_count++;
            end else begin
               want = expected_text.pop_front();
               if (rsp_data.text_char !== want.text_char) begin
                  $error("text_char: expected %h, got %h", want.text_char, rsp_data.text_char);
                  error_count++;
               end
               if (rsp_data.last_char !== want.last_char) begin
                  $error("last_char: expected %b, got %b", want.last_char, rsp_data.last_char);
                  error_count++;
               end
               if (rsp_data.bad_radix !== want.bad_radix) begin
                  $error("bad_radix: expected %b, got %b", want.bad_radix, rsp_data.bad_radix);
                  error_count++;
               end
            end
         end
         if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_drain_pause();
      test_back_to_back();
      test_random();
      start <= 1'b0;
      while (expected_text.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0 && expected_text.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
